// ===== rtl/assert_macros.svh =====
// Assertion macros used by the top level of the pixel sample accumulator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define PSA_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define PSA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define PSA_ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`define PSA_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

// ===== rtl/psa_pkg.sv =====
// Package with sizes, codes, types and the saturating add of the pixel sample accumulator.
package psa_pkg;

   localparam int MAX_WIDTH  = 256;
   localparam int MAX_HEIGHT = 256;
   localparam int PIX_DEPTH  = MAX_WIDTH * MAX_HEIGHT;
   localparam int ADDR_W     = (PIX_DEPTH > 1) ? $clog2(PIX_DEPTH) : 1;
   localparam int XIDX_W     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int YIDX_W     = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

   localparam int DIM_W      = 9;
   localparam int COUNT_W    = 3;
   localparam int COORD_W    = 16;
   localparam int COLOR_W    = 24;
   localparam int SHADOW_W   = 8;
   localparam int SUM_W      = 40;
   localparam int STATUS_W   = 2;
   localparam int LANES      = 4;
   localparam int ENTRY_W    = LANES * SUM_W;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 9;

   // Register indexes of the configuration port.
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_WIDTH     = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_HEIGHT    = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_CHANNEL_COUNT   = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SHADOW_IN_ALPHA = 2'd3;

   localparam logic REQ_ADD  = 1'b0;
   localparam logic REQ_READ = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_ADDED   = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_DROPPED = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_READ    = 2'd2;

   localparam logic [COUNT_W-1:0] COUNT_RESET   = 3'd4;
   localparam logic [COUNT_W-1:0] COUNT_SHADOW  = 3'd4;
   localparam logic [DIM_W-1:0]   WIDTH_RESET   = 9'd256;
   localparam logic [DIM_W-1:0]   HEIGHT_RESET  = 9'd256;

   typedef logic [SUM_W-1:0] sum_type;

   typedef struct packed {
      sum_type lane3;
      sum_type lane2;
      sum_type lane1;
      sum_type lane0;
   } entry_type;

   typedef struct packed {
      logic    clip;
      sum_type sum;
   } sat_type;

   function automatic sat_type sat_add(sum_type acc, logic [COLOR_W-1:0] add);
      logic [SUM_W:0] total;
      sat_type        res;
      total    = {1'b0, acc} + {{(SUM_W + 1 - COLOR_W){1'b0}}, add};
      res.clip = total[SUM_W];
      res.sum  = total[SUM_W] ? {SUM_W{1'b1}} : total[SUM_W-1:0];
      return res;
   endfunction

endpackage

// ===== rtl/psa_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module psa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                             clock,
   input  logic                             wr_en,
   input  logic [$clog2(DEPTH)-1:0]         wr_addr,
   input  logic [WIDTH-1:0]                 wr_data,
   input  logic                             rd_en,
   input  logic [$clog2(DEPTH)-1:0]         rd_addr,
   output logic [WIDTH-1:0]                 rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/pixel_sample_accumulator.sv =====
// Top level of the pixel sample accumulator: control, address path and sum update.
//
// An item is taken when start is high and busy is low. Each item is first
// registered; then the pixel address is formed and the pixel's entry read
// from the sum memory; then the entry is added to, saturated and written
// back. The memory's single read-modify-write per item keeps busy high until
// the write-back, so a new item cannot be taken before the last is through.
// The result shows on the rsp_ ports for one cycle with rsp_valid high; the
// receiver cannot hold it off and must take it then. After reset the block
// clears all MAX_WIDTH*MAX_HEIGHT entries, one entry per cycle, with busy
// high; configuration writes are taken at any time.
module pixel_sample_accumulator (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic                              req_type,
   input  logic [psa_pkg::COORD_W-1:0]       req_pixel_x,
   input  logic [psa_pkg::COORD_W-1:0]       req_pixel_y,
   input  logic [psa_pkg::COLOR_W-1:0]       req_color_red,
   input  logic [psa_pkg::COLOR_W-1:0]       req_color_green,
   input  logic [psa_pkg::COLOR_W-1:0]       req_color_blue,
   input  logic [psa_pkg::SHADOW_W-1:0]      req_shadow_byte,
   input  logic                              req_batch_end,
   output logic                              rsp_valid,
   output logic [psa_pkg::STATUS_W-1:0]      rsp_status,
   output logic [psa_pkg::SUM_W-1:0]         rsp_sum_ch0,
   output logic [psa_pkg::SUM_W-1:0]         rsp_sum_ch1,
   output logic [psa_pkg::SUM_W-1:0]         rsp_sum_ch2,
   output logic [psa_pkg::SUM_W-1:0]         rsp_sum_ch3,
   output logic                              rsp_saturated,
   output logic                              rsp_batch_done,
   input  logic                              csr_wr_en,
   input  logic [psa_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [psa_pkg::CSR_DATA_W-1:0]    csr_wr_data
);

   import psa_pkg::*;

   `include "assert_macros.svh"

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_UPDATE
   } state_type;

   state_type              state_ff, state_in;
   logic [ADDR_W-1:0]      clr_addr_ff, clr_addr_in;

   logic [DIM_W-1:0]       image_width_ff;
   logic [DIM_W-1:0]       image_height_ff;
   logic [COUNT_W-1:0]     channel_count_ff;
   logic                   shadow_in_alpha_ff;

   logic                   type_ff;
   logic [COORD_W-1:0]     x_ff;
   logic [COORD_W-1:0]     y_ff;
   logic [COLOR_W-1:0]     red_ff;
   logic [COLOR_W-1:0]     green_ff;
   logic [COLOR_W-1:0]     blue_ff;
   logic [SHADOW_W-1:0]    shadow_ff;
   logic                   batch_end_ff;
   logic                   in_bounds_ff;
   logic [ADDR_W-1:0]      addr_ff;

   logic                   rsp_valid_ff;
   logic [STATUS_W-1:0]    rsp_status_ff;
   entry_type              rsp_sums_ff;
   logic                   rsp_saturated_ff;
   logic                   rsp_batch_done_ff;

   logic                   accept;
   logic [DIM_W-1:0]       w_eff;
   logic [DIM_W-1:0]       h_eff;
   logic                   in_bounds;
   logic [YIDX_W+DIM_W-1:0] row_base;
   logic [YIDX_W+DIM_W:0]  addr_full;
   logic [ADDR_W-1:0]      addr;

   entry_type              old_entry;
   entry_type              new_entry;
   sat_type                sat0, sat1, sat2, sat3;
   logic                   en0, en1, en2, en3;
   logic                   upd_clip;
   logic [COLOR_W-1:0]     shadow_add;

   logic                   ram_wr_en;
   logic [ADDR_W-1:0]      ram_wr_addr;
   entry_type              ram_wr_data;
   logic [ENTRY_W-1:0]     ram_rd_data;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   // Widths and heights above the store's size are clamped to it.
   assign w_eff = (int'(image_width_ff) > MAX_WIDTH) ? DIM_W'(MAX_WIDTH) : image_width_ff;
   assign h_eff = (int'(image_height_ff) > MAX_HEIGHT) ? DIM_W'(MAX_HEIGHT) : image_height_ff;

   assign in_bounds = (x_ff < {{(COORD_W-DIM_W){1'b0}}, w_eff}) &&
                      (y_ff < {{(COORD_W-DIM_W){1'b0}}, h_eff});

   // In bounds the row index fits YIDX_W bits and the column XIDX_W bits.
   assign row_base  = {{DIM_W{1'b0}}, y_ff[YIDX_W-1:0]} * {{YIDX_W{1'b0}}, w_eff};
   assign addr_full = {1'b0, row_base} +
                      {{(YIDX_W + DIM_W + 1 - XIDX_W){1'b0}}, x_ff[XIDX_W-1:0]};
   assign addr      = addr_full[ADDR_W-1:0];

   // Sum update from the entry read in the previous cycle.
   assign old_entry  = entry_type'(ram_rd_data);
   assign shadow_add = {{(COLOR_W - 2*SHADOW_W){1'b0}}, shadow_ff, shadow_ff};
   assign en0 = (channel_count_ff >= 3'd1);
   assign en1 = (channel_count_ff >= 3'd2);
   assign en2 = (channel_count_ff >= 3'd3);
   assign en3 = shadow_in_alpha_ff && (channel_count_ff == COUNT_SHADOW);

   assign sat0 = sat_add(old_entry.lane0, red_ff);
   assign sat1 = sat_add(old_entry.lane1, green_ff);
   assign sat2 = sat_add(old_entry.lane2, blue_ff);
   assign sat3 = sat_add(old_entry.lane3, shadow_add);

   always_comb begin
      new_entry.lane0 = en0 ? sat0.sum : old_entry.lane0;
      new_entry.lane1 = en1 ? sat1.sum : old_entry.lane1;
      new_entry.lane2 = en2 ? sat2.sum : old_entry.lane2;
      new_entry.lane3 = en3 ? sat3.sum : old_entry.lane3;
      upd_clip = (en0 && sat0.clip) || (en1 && sat1.clip) ||
                 (en2 && sat2.clip) || (en3 && sat3.clip);
   end

   always_comb begin
      if (state_ff == ST_CLEAR) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = clr_addr_ff;
         ram_wr_data = '0;
      end else begin
         ram_wr_en   = (state_ff == ST_UPDATE) && in_bounds_ff && (type_ff == REQ_ADD);
         ram_wr_addr = addr_ff;
         ram_wr_data = new_entry;
      end
   end

   always_comb begin
      state_in    = state_ff;
      clr_addr_in = clr_addr_ff;
      case (state_ff)
         ST_CLEAR: begin
            clr_addr_in = clr_addr_ff + 1'b1;
            if (&clr_addr_ff) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               state_in = ST_READ;
            end
         end
         ST_READ:   state_in = ST_UPDATE;
         ST_UPDATE: state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff           <= ST_CLEAR;
         clr_addr_ff        <= '0;
         image_width_ff     <= WIDTH_RESET;
         image_height_ff    <= HEIGHT_RESET;
         channel_count_ff   <= COUNT_RESET;
         shadow_in_alpha_ff <= 1'b0;
         rsp_valid_ff       <= 1'b0;
      end else begin
         state_ff    <= state_in;
         clr_addr_ff <= clr_addr_in;

         if (csr_wr_en) begin
            case (csr_index)
               CSR_IMAGE_WIDTH:     image_width_ff     <= csr_wr_data[DIM_W-1:0];
               CSR_IMAGE_HEIGHT:    image_height_ff    <= csr_wr_data[DIM_W-1:0];
               CSR_CHANNEL_COUNT:   channel_count_ff   <= csr_wr_data[COUNT_W-1:0];
               CSR_SHADOW_IN_ALPHA: shadow_in_alpha_ff <= csr_wr_data[0];
               default: ;
            endcase
         end

         if (accept) begin
            type_ff      <= req_type;
            x_ff         <= req_pixel_x;
            y_ff         <= req_pixel_y;
            red_ff       <= req_color_red;
            green_ff     <= req_color_green;
            blue_ff      <= req_color_blue;
            shadow_ff    <= req_shadow_byte;
            batch_end_ff <= req_batch_end;
         end

         if (state_ff == ST_READ) begin
            in_bounds_ff <= in_bounds;
            addr_ff      <= addr;
         end

         rsp_valid_ff <= (state_ff == ST_UPDATE);
         if (state_ff == ST_UPDATE) begin
            rsp_batch_done_ff <= batch_end_ff;
            if (!in_bounds_ff) begin
               rsp_status_ff    <= STATUS_DROPPED;
               rsp_sums_ff      <= '0;
               rsp_saturated_ff <= 1'b0;
            end else if (type_ff == REQ_ADD) begin
               rsp_status_ff    <= STATUS_ADDED;
               rsp_sums_ff      <= new_entry;
               rsp_saturated_ff <= upd_clip;
            end else begin
               rsp_status_ff    <= STATUS_READ;
               rsp_sums_ff      <= old_entry;
               rsp_saturated_ff <= 1'b0;
            end
         end
      end
   end

   psa_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (PIX_DEPTH)
   ) u_sum_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (state_ff == ST_READ),
      .rd_addr (addr),
      .rd_data (ram_rd_data)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_sum_ch0    = rsp_sums_ff.lane0;
   assign rsp_sum_ch1    = rsp_sums_ff.lane1;
   assign rsp_sum_ch2    = rsp_sums_ff.lane2;
   assign rsp_sum_ch3    = rsp_sums_ff.lane3;
   assign rsp_saturated  = rsp_saturated_ff;
   assign rsp_batch_done = rsp_batch_done_ff;

   // A result always follows an accepted item, and every accepted item gives one.
   `PSA_ASSERT_IMPL(a_rsp_follows_accept, clock, reset, rsp_valid, $past(accept, 3), "result without a matching item")
   `PSA_ASSERT_NEXT(a_accept_gives_rsp, clock, reset, accept, ##2 rsp_valid, "item gave no result")
   `PSA_ASSERT_IMPL(a_drop_is_zero, clock, reset, rsp_valid && (rsp_status == STATUS_DROPPED), (rsp_sums_ff == '0) && !rsp_saturated, "dropped item reports nonzero sums")
   `PSA_ASSERT_IMPL(a_read_unsaturated, clock, reset, rsp_valid && (rsp_status == STATUS_READ), !rsp_saturated, "read item reports saturation")
   `PSA_ASSERT_IMPL(a_write_only_in_bounds, clock, reset, ram_wr_en && (state_ff != ST_CLEAR), in_bounds_ff && (state_ff == ST_UPDATE), "sum store written outside an update")

endmodule

// ===== tb/pixel_sample_accumulator_test.sv =====
// Self-checking testbench of the pixel sample accumulator: a scoreboard predicts every result.
module pixel_sample_accumulator_test;
   import psa_pkg::*;

   localparam int COLOR_LANES     = 3;
   localparam int SHADOW_LANE     = LANES - 1;
   localparam int SHADOW_SCALE    = 257;
   localparam int SENDER_IDLE_LOW = 21;
   localparam int SENDER_IDLE_HIGH = 77;
   localparam int SEGMENT_ITEMS   = 217;
   localparam int SEGMENTS        = 6;
   localparam int DRAIN_CYCLES    = 10;
   localparam int WATCHDOG_LIMIT  = 262144;

   typedef struct {
      logic                req_type;
      logic [COORD_W-1:0]  pixel_x;
      logic [COORD_W-1:0]  pixel_y;
      logic [COLOR_W-1:0]  color_red;
      logic [COLOR_W-1:0]  color_green;
      logic [COLOR_W-1:0]  color_blue;
      logic [SHADOW_W-1:0] shadow_byte;
      logic                batch_end;
   } sample_type;

   typedef struct {
      logic [STATUS_W-1:0] status;
      logic [SUM_W-1:0]    sum [LANES];
      logic                saturated;
      logic                batch_done;
   } sums_type;

   class scoreboard_type;
      bit [SUM_W-1:0]   lane_sum [LANES][PIX_DEPTH];
      bit [DIM_W-1:0]   width_reg = WIDTH_RESET;
      bit [DIM_W-1:0]   height_reg = HEIGHT_RESET;
      bit [COUNT_W-1:0] count_reg = COUNT_RESET;
      bit               shadow_reg = 1'b0;
      sums_type         expected_sums [$];
      int unsigned      mismatches = 0;

      function void write_register(logic [CSR_INDEX_W-1:0] index,
                                   logic [CSR_DATA_W-1:0] data);
         case (index)
            CSR_IMAGE_WIDTH:     width_reg = data;
            CSR_IMAGE_HEIGHT:    height_reg = data;
            CSR_CHANNEL_COUNT:   count_reg = data[COUNT_W-1:0];
            CSR_SHADOW_IN_ALPHA: shadow_reg = data[0];
            default: ;
         endcase
      endfunction

      function void accumulate_sample(sample_type it);
         sums_type       sums;
         int unsigned    w, h, addr, lanes;
         bit [SUM_W:0]   total;
         bit [SUM_W-1:0] addend [LANES];
         sums.status = STATUS_DROPPED;
         sums.sum = '{default: '0};
         sums.saturated = 1'b0;
         sums.batch_done = it.batch_end;
         w = (width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg;
         h = (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg;
         if (it.pixel_x < w && it.pixel_y < h) begin
            addr = it.pixel_y * w + it.pixel_x;
            if (it.req_type == REQ_ADD) begin
               lanes = (count_reg > COLOR_LANES) ? COLOR_LANES : count_reg;
               addend[0] = it.color_red;
               addend[1] = it.color_green;
               addend[2] = it.color_blue;
               addend[SHADOW_LANE] = it.shadow_byte * SHADOW_SCALE;
               for (int k = 0; k < LANES; k++) begin
                  if (k < lanes ||
                      (k == SHADOW_LANE && shadow_reg && count_reg == COUNT_SHADOW)) begin
                     total = {1'b0, lane_sum[k][addr]} + addend[k];
                     if (total[SUM_W]) begin
                        lane_sum[k][addr] = '1;
                        sums.saturated = 1'b1;
                     end else begin
                        lane_sum[k][addr] = total[SUM_W-1:0];
                     end
                  end
               end
               sums.status = STATUS_ADDED;
            end else begin
               sums.status = STATUS_READ;
            end
            for (int k = 0; k < LANES; k++) sums.sum[k] = lane_sum[k][addr];
         end
         expected_sums.push_back(sums);
      endfunction

      function void compare_field(string name, logic [63:0] want, logic [63:0] seen);
         if (seen !== want) begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, want, seen);
            mismatches++;
         end
      endfunction

      function void check_result(sums_type got);
         sums_type want;
         if (expected_sums.size() == 0) begin
            $error("result with no item pending: status %0d", got.status);
            mismatches++;
            return;
         end
         want = expected_sums.pop_front();
         compare_field("status", want.status, got.status);
         for (int k = 0; k < LANES; k++)
            compare_field($sformatf("sum_ch%0d", k), want.sum[k], got.sum[k]);
         compare_field("saturated", want.saturated, got.saturated);
         compare_field("batch_done", want.batch_done, got.batch_done);
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   start = 1'b0;
   logic                   busy;
   logic                   req_type = REQ_ADD;
   logic [COORD_W-1:0]     req_pixel_x = '0;
   logic [COORD_W-1:0]     req_pixel_y = '0;
   logic [COLOR_W-1:0]     req_color_red = '0;
   logic [COLOR_W-1:0]     req_color_green = '0;
   logic [COLOR_W-1:0]     req_color_blue = '0;
   logic [SHADOW_W-1:0]    req_shadow_byte = '0;
   logic                   req_batch_end = 1'b0;
   logic                   rsp_valid;
   logic [STATUS_W-1:0]    rsp_status;
   logic [SUM_W-1:0]       rsp_sum_ch0;
   logic [SUM_W-1:0]       rsp_sum_ch1;
   logic [SUM_W-1:0]       rsp_sum_ch2;
   logic [SUM_W-1:0]       rsp_sum_ch3;
   logic                   rsp_saturated;
   logic                   rsp_batch_done;
   logic                   csr_wr_en = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wr_data = '0;

   scoreboard_type         sb;
   int unsigned            cfg_width = WIDTH_RESET;
   int unsigned            cfg_height = HEIGHT_RESET;
   int unsigned            idle_cycles = 0;

   pixel_sample_accumulator DUT (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_type        (req_type),
      .req_pixel_x     (req_pixel_x),
      .req_pixel_y     (req_pixel_y),
      .req_color_red   (req_color_red),
      .req_color_green (req_color_green),
      .req_color_blue  (req_color_blue),
      .req_shadow_byte (req_shadow_byte),
      .req_batch_end   (req_batch_end),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_sum_ch0     (rsp_sum_ch0),
      .rsp_sum_ch1     (rsp_sum_ch1),
      .rsp_sum_ch2     (rsp_sum_ch2),
      .rsp_sum_ch3     (rsp_sum_ch3),
      .rsp_saturated   (rsp_saturated),
      .rsp_batch_done  (rsp_batch_done),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wr_data     (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Ports are sampled at the edge, before any of this edge's updates land.
   always @(posedge clock) begin
      sample_type taken;
      sums_type   got;
      if (!reset) begin
         if (csr_wr_en) sb.write_register(csr_index, csr_wr_data);
         if (rsp_valid) begin
            got.status = rsp_status;
            got.sum[0] = rsp_sum_ch0;
            got.sum[1] = rsp_sum_ch1;
            got.sum[2] = rsp_sum_ch2;
            got.sum[3] = rsp_sum_ch3;
            got.saturated = rsp_saturated;
            got.batch_done = rsp_batch_done;
            sb.check_result(got);
         end
         if (start && !busy) begin
            taken.req_type = req_type;
            taken.pixel_x = req_pixel_x;
            taken.pixel_y = req_pixel_y;
            taken.color_red = req_color_red;
            taken.color_green = req_color_green;
            taken.color_blue = req_color_blue;
            taken.shadow_byte = req_shadow_byte;
            taken.batch_end = req_batch_end;
            sb.accumulate_sample(taken);
         end
      end
   end

   // The clearing pass after reset accepts nothing while it clears all PIX_DEPTH entries; the limit covers it.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         idle_cycles <= 0;
      end else if (idle_cycles == WATCHDOG_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic sample_type make_item(logic kind, logic [COORD_W-1:0] x,
                                            logic [COORD_W-1:0] y, logic [COLOR_W-1:0] red,
                                            logic [COLOR_W-1:0] green,
                                            logic [COLOR_W-1:0] blue,
                                            logic [SHADOW_W-1:0] shadow, logic last);
      sample_type it;
      it.req_type = kind;
      it.pixel_x = x;
      it.pixel_y = y;
      it.color_red = red;
      it.color_green = green;
      it.color_blue = blue;
      it.shadow_byte = shadow;
      it.batch_end = last;
      return it;
   endfunction

   function automatic logic [COLOR_W-1:0] random_color();
      case ($urandom_range(7))
         0: return '0;
         1: return '1;
         default: return COLOR_W'($urandom);
      endcase
   endfunction

   function automatic sample_type random_sample();
      sample_type  it;
      int unsigned w, h, pick;
      w = (cfg_width > MAX_WIDTH) ? MAX_WIDTH : cfg_width;
      h = (cfg_height > MAX_HEIGHT) ? MAX_HEIGHT : cfg_height;
      pick = $urandom_range(99);
      it.req_type = ($urandom_range(99) < 20) ? REQ_READ : REQ_ADD;
      it.color_red = random_color();
      it.color_green = random_color();
      it.color_blue = random_color();
      it.shadow_byte = SHADOW_W'($urandom);
      it.batch_end = 1'($urandom_range(1));
      if (w == 0 || h == 0 || pick < 8) begin
         it.pixel_x = COORD_W'($urandom);
         it.pixel_y = COORD_W'($urandom);
      end else if (pick < 14) begin
         // One step past the right or the bottom edge.
         it.pixel_x = COORD_W'((pick < 11) ? w : $urandom_range(w - 1));
         it.pixel_y = COORD_W'((pick < 11) ? $urandom_range(h - 1) : h);
      end else if (pick < 60) begin
         // A corner of a few pixels, so that sums grow over many items.
         it.pixel_x = COORD_W'($urandom_range((w < 4) ? w - 1 : 3));
         it.pixel_y = COORD_W'($urandom_range((h < 4) ? h - 1 : 3));
      end else begin
         it.pixel_x = COORD_W'($urandom_range(w - 1));
         it.pixel_y = COORD_W'($urandom_range(h - 1));
      end
      return it;
   endfunction

   // Leaves start high after acceptance, so the next item can follow without a gap.
   task automatic send_item(input sample_type it, input int unsigned idle_pct);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_type <= it.req_type;
      req_pixel_x <= it.pixel_x;
      req_pixel_y <= it.pixel_y;
      req_color_red <= it.color_red;
      req_color_green <= it.color_green;
      req_color_blue <= it.color_blue;
      req_shadow_byte <= it.shadow_byte;
      req_batch_end <= it.batch_end;
      do @(posedge clock); while (busy !== 1'b0);
   endtask

   task automatic wait_for_results();
      start <= 1'b0;
      @(posedge clock);
      while (sb.expected_sums.size() != 0) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wr_data <= data;
      @(posedge clock);
   endtask

   // Every item yields one result, so the block is idle once none is pending.
   task automatic configure(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
                            input logic [COUNT_W-1:0] count, input logic shadow);
      wait_for_results();
      cfg_width = w;
      cfg_height = h;
      write_csr(CSR_IMAGE_WIDTH, w);
      write_csr(CSR_IMAGE_HEIGHT, h);
      // Random bits above the field check that the block ignores them.
      write_csr(CSR_CHANNEL_COUNT, CSR_DATA_W'({$urandom, count}));
      write_csr(CSR_SHADOW_IN_ALPHA, CSR_DATA_W'({$urandom, shadow}));
      csr_wr_en <= 1'b0;
   endtask

   initial begin
      sb = new();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      configure(256, 256, 4, 1'b1);
      send_item(make_item(REQ_ADD, 0, 0, '1, '1, '1, '1, 1'b1), SENDER_IDLE_LOW);
      send_item(make_item(REQ_ADD, 0, 0, '0, '0, '0, '0, 1'b0), SENDER_IDLE_LOW);
      send_item(make_item(REQ_READ, 0, 0, '0, '0, '0, '0, 1'b0), SENDER_IDLE_LOW);
      send_item(make_item(REQ_ADD, 255, 255, 24'h555555, 24'hAAAAAA, 24'h123456, 8'hAA,
                          1'b1), SENDER_IDLE_LOW);
      send_item(make_item(REQ_READ, 255, 255, '1, '1, '1, '1, 1'b1), SENDER_IDLE_LOW);
      send_item(make_item(REQ_ADD, 256, 0, '1, '1, '1, '1, 1'b0), SENDER_IDLE_LOW);
      send_item(make_item(REQ_READ, 0, 256, '0, '0, '0, '0, 1'b1), SENDER_IDLE_LOW);
      send_item(make_item(REQ_ADD, '1, '1, '1, '1, '1, '1, 1'b1), SENDER_IDLE_LOW);
      send_item(make_item(REQ_ADD, 16'hAAAA, 16'h5555, '1, '0, '1, 8'h55, 1'b0),
                SENDER_IDLE_LOW);
      send_item(make_item(REQ_READ, 128, 64, '0, '0, '0, '0, 1'b0), SENDER_IDLE_LOW);

      // Zero width: nothing is inside the image.
      configure(0, 256, 4, 1'b1);
      send_item(make_item(REQ_ADD, 0, 0, '1, '1, '1, '1, 1'b1), SENDER_IDLE_LOW);

      // Oversized width and height fall back to the maximum image.
      configure(511, 300, 3, 1'b1);
      send_item(make_item(REQ_ADD, 255, 255, '1, '1, '1, '1, 1'b0), SENDER_IDLE_LOW);
      send_item(make_item(REQ_ADD, 3, 299, '1, '1, '1, '1, 1'b1), SENDER_IDLE_LOW);
      send_item(make_item(REQ_READ, 255, 255, '0, '0, '0, '0, 1'b0), SENDER_IDLE_LOW);

      // No channels: the add is reported but changes nothing.
      configure(1, 1, 0, 1'b1);
      send_item(make_item(REQ_ADD, 0, 0, '1, '1, '1, '1, 1'b1), SENDER_IDLE_LOW);
      send_item(make_item(REQ_ADD, 1, 0, '1, '1, '1, '1, 1'b0), SENDER_IDLE_LOW);

      configure(256, 256, 7, 1'b1);
      send_item(make_item(REQ_ADD, 5, 5, '1, '1, '1, '1, 1'b0), SENDER_IDLE_LOW);
      configure(256, 256, 1, 1'b0);
      send_item(make_item(REQ_ADD, 5, 5, 24'h0F0F0F, '1, '1, '1, 1'b0), SENDER_IDLE_LOW);
      configure(256, 256, 2, 1'b0);
      send_item(make_item(REQ_ADD, 5, 5, '1, 24'hF0F0F0, '1, '1, 1'b0), SENDER_IDLE_LOW);
      configure(256, 256, 4, 1'b0);
      send_item(make_item(REQ_ADD, 5, 5, '1, '1, '1, '1, 1'b0), SENDER_IDLE_LOW);
      configure(256, 256, 4, 1'b1);
      send_item(make_item(REQ_ADD, 5, 5, '1, '1, '1, 8'h80, 1'b1), SENDER_IDLE_LOW);
      send_item(make_item(REQ_READ, 5, 5, '0, '0, '0, '0, 1'b0), SENDER_IDLE_LOW);

      for (int seg = 0; seg < SEGMENTS; seg++) begin
         case (seg)
            0: configure(256, 256, 4, 1'b1);
            2: configure(1, 1, 4, 1'b1);
            4: configure(511, 511, 4, 1'b1);
            default: configure(DIM_W'(($urandom_range(3) == 0) ? $urandom_range(511)
                                                               : $urandom_range(16, 1)),
                               DIM_W'(($urandom_range(3) == 0) ? $urandom_range(511)
                                                               : $urandom_range(16, 1)),
                               COUNT_W'($urandom_range(7)), 1'($urandom_range(1)));
         endcase
         for (int n = 0; n < SEGMENT_ITEMS; n++)
            send_item(random_sample(), (seg < 2) ? SENDER_IDLE_LOW :
                                       (seg < 4) ? SENDER_IDLE_HIGH : 0);
      end

      wait_for_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.mismatches == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
